// ===== design/lbvs_pkg.sv =====
// Package with shared types and constants of the vertex skinning core.
`default_nettype none
package lbvs_pkg;

  localparam int unsigned BonesDefault      = 64;
  localparam int unsigned InfluencesDefault = 4;
  localparam int unsigned WordsPerBone      = 12;
  localparam int unsigned MaxInfluences     = 4;

  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_SKIN = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BLEND,
    ST_ROUND,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch a vertex request
    logic       load;       // write one palette word
    logic       clear_acc;  // clear blend accumulators
    logic       rd_en;      // read palette row of influence inf
    logic [1:0] inf;        // influence being read
    logic       acc_en;     // accumulate registered row
    logic       round_en;   // round and saturate blend
    logic       mul_en;     // form products for output row
    logic       sum_en;     // sum products into result slot
    logic [1:0] row;        // output row 0..2
    logic       out_load;   // move results to output register
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds an untaken result
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/lbvs_ctrl.sv =====
// Controller state machine that sequences palette reads and the transform.
`default_nettype none
module lbvs_ctrl import lbvs_pkg::*; #(
  parameter int unsigned Influences = InfluencesDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_kind_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.inf  = cnt_q;
    cmd_o.row  = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture   = 1'b1;
            cmd_o.clear_acc = 1'b1;
            cnt_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.acc_en = 1'b1;
        if (32'(cnt_q) == Influences - 1) begin
          cnt_d   = '0;
          state_d = ST_ROUND;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_READ;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (cnt_q == 2'd2) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/lbvs_datapath.sv =====
// Datapath: bone palette memory, weighted blend and the matrix transform.
`default_nettype none
module lbvs_datapath import lbvs_pkg::*; #(
  parameter int unsigned Bones = BonesDefault
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  wire         [31:0] bone_ids_i,
  input  wire         [63:0] bone_weights_i,
  input  wire  signed [31:0] pos_i [3],
  input  wire  signed [31:0] nrm_i [3],
  input  wire         [5:0]  load_bone_i,
  input  wire         [3:0]  load_element_i,
  input  wire  signed [31:0] load_value_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] out_o [6]
);

  localparam int unsigned BoneW = (Bones > 1) ? $clog2(Bones) : 1;

  // One palette row holds all twelve words of a bone.
  logic [WordsPerBone*32-1:0] mem [Bones];
  logic [WordsPerBone*32-1:0] row_q;
  logic                       row_ok_q;
  logic [15:0]                wgt_q;

  logic [31:0]        ids_q;
  logic [63:0]        wts_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nrm_q [3];

  logic signed [49:0] acc_q   [WordsPerBone];
  logic signed [48:0] bprod   [WordsPerBone];
  logic signed [31:0] blend_q [WordsPerBone];
  logic signed [63:0] pp_q    [3];
  logic signed [63:0] np_q    [3];
  logic signed [31:0] res_q   [6];
  logic               out_valid_q;

  logic [7:0] cur_id;
  assign cur_id = ids_q[8*cmd_i.inf +: 8];

  logic [BoneW-1:0] wr_bone;
  assign wr_bone = BoneW'(load_bone_i);

  // Palette write: words of a row are written individually.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(load_bone_i) < Bones) && (load_element_i < 4'(WordsPerBone))) begin
      mem[wr_bone][32*load_element_i +: 32] <= load_value_i;
    end
    if (cmd_i.rd_en) begin
      row_q <= mem[cur_id[BoneW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ids_q <= bone_ids_i;
      wts_q <= bone_weights_i;
      pos_q <= pos_i;
      nrm_q <= nrm_i;
    end
    if (cmd_i.rd_en) begin
      row_ok_q <= (32'(cur_id) < Bones);
      wgt_q    <= wts_q[16*cmd_i.inf +: 16];
    end
  end

  // Weight times palette word, one 17x32 product per element.
  always_comb begin
    for (int e = 0; e < WordsPerBone; e++) begin
      bprod[e] = $signed({1'b0, wgt_q}) * $signed(row_q[32*e +: 32]);
    end
  end

  // Blend accumulation: twelve 16x32 products per cycle in which acc_en is set.
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < WordsPerBone; e++) begin
      if (cmd_i.clear_acc) begin
        acc_q[e] <= '0;
      end else if (cmd_i.acc_en && row_ok_q) begin
        acc_q[e] <= acc_q[e] + 50'(bprod[e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < WordsPerBone; e++) begin
      if (cmd_i.round_en) begin
        blend_q[e] <= sat32(64'((acc_q[e] + 50'sd16384) >>> 15));
      end
    end
  end

  // Per output row: three position and three normal products.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (cmd_i.mul_en) begin
        pp_q[j] <= 64'(blend_q[4*cmd_i.row + j]) * 64'(pos_q[j]);
        np_q[j] <= 64'(blend_q[4*cmd_i.row + j]) * 64'(nrm_q[j]);
      end
    end
  end

  logic signed [65:0] psum, nsum;
  logic signed [63:0] pres, nres;
  always_comb begin
    psum = 66'(pp_q[0]) + 66'(pp_q[1]) + 66'(pp_q[2]) + 66'sd32768;
    nsum = 66'(np_q[0]) + 66'(np_q[1]) + 66'(np_q[2]) + 66'sd32768;
    pres = 64'(psum >>> 16) + 64'(blend_q[4*cmd_i.row + 3]);
    nres = 64'(nsum >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      res_q[cmd_i.row]     <= sat32(pres);
      res_q[cmd_i.row + 3] <= sat32(nres);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// ===== design/linear_blend_vertex_skinning_core.sv =====
// Top level of the linear blend vertex skinning core.
`default_nettype none
// This core keeps a palette of bone matrices (top three rows, twelve Q16.16
// words per bone) and skins vertices with up to four weighted influences.
// A request with kind 0 writes one palette word, and the core stays ready; it
// gives no result. A request with kind 1 blends the matrices of its bones,
// then transforms the position (translation included) and the normal
// (translation left out), saturating all results to Q16.16. The palette
// memory has one read port returning a full bone row per cycle, so each
// influence costs a read and an accumulate step, and the three output rows
// are then formed one at a time through a shared multiply and sum stage.
// The finished result waits in an output register, and a new request is
// taken as soon as that result has been moved there. Palette words must be
// written before a vertex reads them; bones with an index of BONES or more
// contribute nothing.
module linear_blend_vertex_skinning_core import lbvs_pkg::*; #(
  parameter int unsigned BONES      = BonesDefault,
  parameter int unsigned INFLUENCES = InfluencesDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0: bone_ids 31:0, bone_weights 95:32, pos_x 127:96,
  // pos_y 159:128, pos_z 191:160, nrm_x 223:192, nrm_y 255:224,
  // nrm_z 287:256, load_bone 293:288, load_element 297:294,
  // load_value 329:298, zero 335:330.
  input  wire  [335:0] s_axis_tdata_i,
  // kind.
  input  wire          s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // out_pos_x 31:0, out_pos_y 63:32, out_pos_z 95:64, out_nrm_x 127:96,
  // out_nrm_y 159:128, out_nrm_z 191:160.
  output logic [191:0] m_axis_tdata_o
);

  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] pos [3];
  logic signed [31:0] nrm [3];
  logic signed [31:0] res [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = s_axis_tdata_i[96 + 32*i +: 32];
      nrm[i] = s_axis_tdata_i[192 + 32*i +: 32];
    end
    for (int i = 0; i < 6; i++) begin
      m_axis_tdata_o[32*i +: 32] = res[i];
    end
  end

  lbvs_ctrl #(.Influences(INFLUENCES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbvs_datapath #(.Bones(BONES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bone_ids_i     (s_axis_tdata_i[31:0]),
    .bone_weights_i (s_axis_tdata_i[95:32]),
    .pos_i          (pos),
    .nrm_i          (nrm),
    .load_bone_i    (s_axis_tdata_i[293:288]),
    .load_element_i (s_axis_tdata_i[297:294]),
    .load_value_i   (s_axis_tdata_i[329:298]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_o          (res)
  );

endmodule
`default_nettype wire

// ===== verif/tb_linear_blend_vertex_skinning_core.sv =====
// Testbench for the linear blend vertex skinning core: predicts and checks skinned vertices.
`default_nettype none
module tb_linear_blend_vertex_skinning_core import lbvs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBones = BonesDefault;
  localparam int unsigned NumInf   = InfluencesDefault;

  typedef struct packed {
    logic signed [31:0] nrm_z, nrm_y, nrm_x, pos_z, pos_y, pos_x;
  } skinned_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [335:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [191:0] m_axis_tdata_o;

  // Palette copy and a record of which words were written since reset.
  logic signed [31:0] palette_q [NumBones*WordsPerBone];
  bit                 written_q [NumBones*WordsPerBone];
  bit                 bone_ready[NumBones];
  skinned_t           pending_vertices[$];
  int unsigned        error_count = 0;
  bit                 sink_busy_mode = 1'b1;
  bit                 source_busy_mode = 1'b1;

  linear_blend_vertex_skinning_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [63:0] floor_div(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Output component: exact product sum in Q.32, rounded once, translation added when tr is set.
  function automatic logic signed [31:0] row_apply(input logic signed [63:0] b[12], input int r,
                                                   input logic signed [31:0] v[3], input bit tr);
    logic signed [63:0] hi, lo, p, h;
    hi = 0; lo = 0;
    for (int j = 0; j < 3; j++) begin
      p = b[r*4+j] * 64'(v[j]);
      h = floor_div(p, 16);
      hi += h;
      lo += p - (h <<< 16);
    end
    hi += floor_div(lo + 64'sd32768, 16);
    if (tr) hi += b[r*4+3];
    return clamp32(hi);
  endfunction

  function automatic skinned_t skin_vertex(input logic [335:0] d);
    logic signed [63:0] blend[12];
    logic signed [63:0] acc;
    logic signed [31:0] p[3], n[3];
    logic [7:0]  id;
    skinned_t    res;
    for (int e = 0; e < WordsPerBone; e++) begin
      acc = 0;
      for (int k = 0; k < NumInf; k++) begin
        id = d[8*k +: 8];
        if (id < NumBones)
          acc += $signed({48'd0, d[32+16*k +: 16]}) * 64'(palette_q[id*WordsPerBone+e]);
      end
      blend[e] = clamp32(floor_div(acc + 64'sd16384, 15));
    end
    for (int r = 0; r < 3; r++) begin
      p[r] = d[96+32*r +: 32];
      n[r] = d[192+32*r +: 32];
    end
    res.pos_x = row_apply(blend, 0, p, 1); res.pos_y = row_apply(blend, 1, p, 1);
    res.pos_z = row_apply(blend, 2, p, 1); res.nrm_x = row_apply(blend, 0, n, 0);
    res.nrm_y = row_apply(blend, 1, n, 0); res.nrm_z = row_apply(blend, 2, n, 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t: mismatch %s got %h expected %h", $realtime, what, got, exp);
    error_count++;
  endtask

  // Sends one request and updates the prediction at acceptance. Valid stays
  // high after acceptance so that a following request can go out back to
  // back; it drops while the source idles and at the end of the run.
  task automatic send_request(input kind_e kind, input logic [335:0] d);
    int idx;
    while (source_busy_mode && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (kind == KIND_LOAD) begin
      if (d[293:288] < NumBones && d[297:294] < WordsPerBone) begin
        idx = d[293:288] * WordsPerBone + d[297:294];
        palette_q[idx] = d[329:298];
        written_q[idx] = 1'b1;
        bone_ready[d[293:288]] = 1'b1;
        for (int e = 0; e < WordsPerBone; e++)
          if (!written_q[d[293:288]*WordsPerBone+e]) bone_ready[d[293:288]] = 1'b0;
      end
    end else begin
      pending_vertices = {pending_vertices, skin_vertex(d)};
    end
  endtask

  task automatic load_word(input int bone, input int elem, input logic [31:0] val);
    logic [335:0] d;
    d = 336'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom});
    d[293:288] = 6'(bone); d[297:294] = 4'(elem); d[329:298] = val; d[335:330] = '0;
    send_request(KIND_LOAD, d);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Bone index for a vertex: a loaded bone, or sometimes an out-of-range one.
  function automatic logic [7:0] pick_bone();
    int b;
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, NumBones));
    do b = $urandom_range(NumBones - 1); while (!bone_ready[b]);
    return 8'(b);
  endfunction

  task automatic skin(input logic [31:0] ids, input logic [63:0] w,
                      input logic [191:0] vec);
    send_request(KIND_SKIN, {6'd0, 32'($urandom), 4'($urandom), 6'($urandom), vec, w, ids});
  endtask

  task automatic random_vertex();
    logic [31:0] ids;
    logic [63:0] w;
    logic [191:0] vec;
    for (int k = 0; k < 4; k++) begin
      ids[8*k +: 8] = pick_bone();
      w[16*k +: 16] = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
    end
    for (int c = 0; c < 6; c++) vec[32*c +: 32] = rand_word();
    skin(ids, w, vec);
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    skinned_t got, exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected result", got.pos_x, '0);
      end else begin
        exp = pending_vertices.pop_front();
        if (got.pos_x !== exp.pos_x) report_mismatch("pos_x", got.pos_x, exp.pos_x);
        if (got.pos_y !== exp.pos_y) report_mismatch("pos_y", got.pos_y, exp.pos_y);
        if (got.pos_z !== exp.pos_z) report_mismatch("pos_z", got.pos_z, exp.pos_z);
        if (got.nrm_x !== exp.nrm_x) report_mismatch("nrm_x", got.nrm_x, exp.nrm_x);
        if (got.nrm_y !== exp.nrm_y) report_mismatch("nrm_y", got.nrm_y, exp.nrm_y);
        if (got.nrm_z !== exp.nrm_z) report_mismatch("nrm_z", got.nrm_z, exp.nrm_z);
      end
    end
    m_axis_tready_i <= !(sink_busy_mode && $urandom_range(99) < 13);
  end

  // Identity and extreme palette entries, then the field extremes on vertices.
  task automatic test_directed();
    for (int b = 0; b < 3; b++)
      for (int e = 0; e < WordsPerBone; e++)
        load_word(b, e, b == 0 ? ((e % 5 == 0) ? 32'h00010000 : 32'h0)
                               : (b == 1 ? 32'h7fffffff : 32'h80000000));
    load_word(0, 12, 32'h1234);          // element out of range, ignored
    load_word(0, 15, 32'h1234);
    skin(32'h00000000, 64'h0000_0000_0000_8000, {6{32'h00018000}});
    skin(32'h02010201, 64'hffff_ffff_ffff_ffff, {3{32'h80000000, 32'h7fffffff}});
    skin(32'hff40_0100, 64'hffff_ffff_8000_8000, {6{32'hffffffff}});
    skin(32'hffffffff, 64'h0000_0000_0000_0000, {6{32'h7fffffff}});
    skin(32'h00000102, 64'h0001_0001_0001_0001, {6{32'h80000000}});
  endtask

  task automatic test_random_palette();
    for (int b = 0; b < NumBones; b++)
      for (int e = 0; e < WordsPerBone; e++)
        if (b < 8 || $urandom_range(7) == 0) load_word(b, e, rand_word());
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 330; i++) begin
      if (i == 150) begin sink_busy_mode = 0; source_busy_mode = 0; end
      if (i == 250) begin sink_busy_mode = 1; source_busy_mode = 1; end
      if ($urandom_range(4) == 0)
        load_word($urandom_range(NumBones - 1), $urandom_range(WordsPerBone - 1), rand_word());
      else
        random_vertex();
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < NumBones*WordsPerBone; i++) begin
      palette_q[i] = '0; written_q[i] = 1'b0;
    end
    for (int b = 0; b < NumBones; b++) bone_ready[b] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_palette();
    test_random_mix();
    s_axis_tvalid_i <= 1'b0;
    guard = 0;
    while (pending_vertices.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_vertices.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
